/* hw/rtl/aigsim_pkg.sv */
// ----------------------------------------------------------------------------
// AIG simulator package
// Shared widths, codes, the classified work item and the row reduction used
// by the front end of the bit-parallel and-inverter graph simulator.
// ----------------------------------------------------------------------------
package aigsim_pkg;

    localparam int NODE_W        = 10;
    localparam int WORD_W        = 3;
    localparam int DATA_W        = 64;
    localparam int KIND_W        = 2;
    localparam int CFG_W         = 4;

    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_WORDS_DEF = 8;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INPUT  = 2'd0,
        KIND_AND    = 2'd1,
        KIND_OUTPUT = 2'd2
    } kind_t;

    // What the back end does with an item.
    typedef enum logic [1:0] {
        OP_ZERO,
        OP_PATTERN,
        OP_AND,
        OP_PASS
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [NODE_W-1:0] node;
        logic [WORD_W-1:0] word;
        logic [NODE_W-1:0] node_row;
        logic [NODE_W-1:0] fa_row;
        logic [NODE_W-1:0] fb_row;
        logic              zero_a;
        logic              zero_b;
        logic              inv_a;
        logic              inv_b;
        logic              write_en;
        logic              order_error;
        logic [DATA_W-1:0] pattern;
    } work_t;

    // Node index modulo the node count, by restoring compare and subtract.
    function automatic logic [NODE_W-1:0] row_of(input logic [NODE_W-1:0] idx,
                                                 input int unsigned   nodes);
        logic [NODE_W:0] rem;
        rem = '0;
        if (nodes >= (1 << NODE_W))
        begin
            return idx;
        end
        for (int i = NODE_W - 1; i >= 0; i--)
        begin
            rem = {rem[NODE_W-1:0], idx[i]};
            if (32'(rem) >= nodes)
            begin
                rem = rem - (NODE_W + 1)'(nodes);
            end
        end
        return rem[NODE_W-1:0];
    endfunction

endpackage

/* hw/rtl/aigsim_ifs.sv */
// ----------------------------------------------------------------------------
// AIG simulator channels
// Valid/ready channels for the node items and the simulation results.
// ----------------------------------------------------------------------------
interface aigsim_in_if;
    import aigsim_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] node_kind;
    logic [NODE_W-1:0] node_index;
    logic [WORD_W-1:0] word_index;
    logic [NODE_W-1:0] fanin_a;
    logic              invert_a;
    logic [NODE_W-1:0] fanin_b;
    logic              invert_b;
    logic [DATA_W-1:0] pattern_word;

    modport source (
        output valid, node_kind, node_index, word_index,
        output fanin_a, invert_a, fanin_b, invert_b, pattern_word,
        input  ready
    );

    modport sink (
        input  valid, node_kind, node_index, word_index,
        input  fanin_a, invert_a, fanin_b, invert_b, pattern_word,
        output ready
    );
endinterface

interface aigsim_out_if;
    import aigsim_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] sim_word;
    logic [NODE_W-1:0] node_out;
    logic [WORD_W-1:0] word_out;
    logic              order_error;

    modport source (
        output valid, sim_word, node_out, word_out, order_error,
        input  ready
    );

    modport sink (
        input  valid, sim_word, node_out, word_out, order_error,
        output ready
    );
endinterface

/* hw/rtl/aig_bit_parallel_simulator.sv */
// ----------------------------------------------------------------------------
// Bit-parallel AIG simulator
// Evaluates an and-inverter graph 64 patterns per word, one node word per
// item, and returns every item's word with its node and word index.
// ----------------------------------------------------------------------------
// The block takes one item per clock and returns one result per clock when
// the result side keeps ready high; an item passes the queue, the evaluate
// stage and the output register. That rate is set by the word store, which
// reads both fanin words and writes the node word in the same cycle on two
// read ports and one write port, with the word being written forwarded to a
// dependent item right behind it. Items must come in topological order; an
// entry of a node other than node zero reads back only what was written to
// it since reset, and no clearing pass runs after reset. The user must write
// the word count only while the block is idle; the block does not enforce it.
module aig_bit_parallel_simulator #(
    parameter int MAX_NODES = aigsim_pkg::MAX_NODES_DEF,
    parameter int MAX_WORDS = aigsim_pkg::MAX_WORDS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [aigsim_pkg::CFG_W-1:0] cfg_wdata,
    aigsim_in_if.sink                    items,
    aigsim_out_if.source                 results
);
    import aigsim_pkg::*;

    work_t push_item;
    logic  push_valid;
    logic  push_ready;
    work_t head_item;
    logic  head_valid;
    logic  pop;

    aigsim_front #(
        .MAX_NODES (MAX_NODES),
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .items      (items),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    aigsim_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .head_item  (head_item),
        .head_valid (head_valid),
        .pop        (pop)
    );

    aigsim_back #(
        .MAX_NODES (MAX_NODES),
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .head_valid (head_valid),
        .pop        (pop),
        .results    (results)
    );

endmodule

/* hw/rtl/aigsim_front.sv */
// ----------------------------------------------------------------------------
// AIG simulator front end
// Holds the word-count register, accepts node items and classifies them
// into work items: operation, store rows, write enable and order flag.
// ----------------------------------------------------------------------------
module aigsim_front #(
    parameter int MAX_NODES = aigsim_pkg::MAX_NODES_DEF,
    parameter int MAX_WORDS = aigsim_pkg::MAX_WORDS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [aigsim_pkg::CFG_W-1:0] cfg_wdata,
    aigsim_in_if.sink                    items,
    output aigsim_pkg::work_t            push_item,
    output logic                         push_valid,
    input  logic                         push_ready
);
    import aigsim_pkg::*;

    logic [CFG_W-1:0]  words_in_use_reg;
    logic [CFG_W-1:0]  words_in_use_next;
    kind_t             kind;
    logic              word_ok;
    logic              fa_late;
    logic              fb_late;
    logic [NODE_W-1:0] node_row;
    logic [NODE_W-1:0] fa_row;
    logic [NODE_W-1:0] fb_row;
    op_t               op;
    logic              err;

    always_comb
    begin
        words_in_use_next = cfg_we ? cfg_wdata : words_in_use_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_in_use_reg <= CFG_W'(1);
        end
        else
        begin
            words_in_use_reg <= words_in_use_next;
        end
    end

    // A zero word count behaves as one word.
    always_comb
    begin
        kind    = kind_t'(items.node_kind);
        word_ok = (32'(items.word_index) < MAX_WORDS)
               && (({1'b0, items.word_index} < words_in_use_reg)
                   || (items.word_index == '0));
        fa_late = items.fanin_a >= items.node_index;
        fb_late = items.fanin_b >= items.node_index;
        node_row = row_of(items.node_index, MAX_NODES);
        fa_row   = row_of(items.fanin_a, MAX_NODES);
        fb_row   = row_of(items.fanin_b, MAX_NODES);

        unique case (kind)
            KIND_INPUT:
            begin
                op  = OP_PATTERN;
                err = 1'b0;
            end
            KIND_AND:
            begin
                op  = OP_AND;
                err = fa_late || fb_late;
            end
            KIND_OUTPUT:
            begin
                op  = OP_PASS;
                err = fa_late;
            end
            default:
            begin
                op  = OP_ZERO;
                err = 1'b0;
            end
        endcase

        if (!word_ok)
        begin
            op  = OP_ZERO;
            err = 1'b0;
        end
    end

    always_comb
    begin
        push_item.op          = op;
        push_item.node        = items.node_index;
        push_item.word        = items.word_index;
        push_item.node_row    = node_row;
        push_item.fa_row      = fa_row;
        push_item.fb_row      = fb_row;
        push_item.zero_a      = fa_row == '0;
        push_item.zero_b      = fb_row == '0;
        push_item.inv_a       = items.invert_a;
        push_item.inv_b       = items.invert_b;
        push_item.write_en    = (op != OP_ZERO) && (node_row != '0);
        push_item.order_error = err;
        push_item.pattern     = items.pattern_word;
        push_valid            = items.valid;
        items.ready           = push_ready;
    end

endmodule

/* hw/rtl/aigsim_queue.sv */
// ----------------------------------------------------------------------------
// AIG simulator work queue
// Short FIFO of classified work items between the front and back ends.
// ----------------------------------------------------------------------------
module aigsim_queue #(
    parameter int DEPTH = aigsim_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  aigsim_pkg::work_t push_item,
    input  logic              push_valid,
    output logic              push_ready,
    output aigsim_pkg::work_t head_item,
    output logic              head_valid,
    input  logic              pop
);
    import aigsim_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t            entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;

    always_comb
    begin
        push_ready = count_reg != CNT_W'(DEPTH);
        head_valid = count_reg != '0;
        head_item  = entries_reg[rd_ptr_reg];
        push       = push_valid && push_ready;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end

        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hw/rtl/aigsim_back.sv */
// ----------------------------------------------------------------------------
// AIG simulator back end
// Word store with two read ports and one write port, an evaluate stage with
// forwarding of the word being written, and the result output register.
// ----------------------------------------------------------------------------
module aigsim_back #(
    parameter int MAX_NODES = aigsim_pkg::MAX_NODES_DEF,
    parameter int MAX_WORDS = aigsim_pkg::MAX_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  aigsim_pkg::work_t head_item,
    input  logic              head_valid,
    output logic              pop,
    aigsim_out_if.source      results
);
    import aigsim_pkg::*;

    localparam int MEM_DEPTH = MAX_NODES * MAX_WORDS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    function automatic logic [ADDR_W-1:0] addr_of(input logic [NODE_W-1:0] row,
                                                   input logic [WORD_W-1:0] word);
        return ADDR_W'(32'(row) * MAX_WORDS + 32'(word));
    endfunction

    logic [DATA_W-1:0] mem [MEM_DEPTH];

    logic              s1_valid_reg;
    logic              s1_valid_next;
    work_t             s1_item_reg;
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;
    logic              fwd_a_reg;
    logic              fwd_b_reg;
    logic [DATA_W-1:0] fwd_word_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_word_reg;
    logic [NODE_W-1:0] out_node_reg;
    logic [WORD_W-1:0] out_wordidx_reg;
    logic              out_err_reg;

    logic              s1_adv;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    logic [DATA_W-1:0] a_val;
    logic [DATA_W-1:0] b_val;
    logic [DATA_W-1:0] result;

    always_comb
    begin
        s1_adv    = s1_valid_reg && (!out_valid_reg || results.ready);
        pop       = head_valid && (!s1_valid_reg || s1_adv);
        rd_addr_a = addr_of(head_item.fa_row, head_item.word);
        rd_addr_b = addr_of(head_item.fb_row, head_item.word);
        wr_addr   = addr_of(s1_item_reg.node_row, s1_item_reg.word);
        wr_en     = s1_adv && s1_item_reg.write_en;

        // The store read returns the old word when the evaluate stage writes
        // the same entry in that cycle, so that word is taken from the stage.
        if (s1_item_reg.zero_a)
        begin
            a_val = '0;
        end
        else
        begin
            a_val = fwd_a_reg ? fwd_word_reg : rd_a_reg;
        end
        if (s1_item_reg.zero_b)
        begin
            b_val = '0;
        end
        else
        begin
            b_val = fwd_b_reg ? fwd_word_reg : rd_b_reg;
        end
        a_val = a_val ^ {DATA_W{s1_item_reg.inv_a}};
        b_val = b_val ^ {DATA_W{s1_item_reg.inv_b}};

        unique case (s1_item_reg.op)
            OP_PATTERN: result = s1_item_reg.pattern;
            OP_AND:     result = a_val & b_val;
            OP_PASS:    result = a_val;
            default:    result = '0;
        endcase

        s1_valid_next = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= result;
        end
        if (pop)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_item_reg  <= head_item;
            fwd_a_reg    <= wr_en && (rd_addr_a == wr_addr);
            fwd_b_reg    <= wr_en && (rd_addr_b == wr_addr);
            fwd_word_reg <= result;
        end
        if (s1_adv)
        begin
            out_word_reg    <= result;
            out_node_reg    <= s1_item_reg.node;
            out_wordidx_reg <= s1_item_reg.word;
            out_err_reg     <= s1_item_reg.order_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        results.valid       = out_valid_reg;
        results.sim_word    = out_word_reg;
        results.node_out    = out_node_reg;
        results.word_out    = out_wordidx_reg;
        results.order_error = out_err_reg;
    end

endmodule

/* hw/rtl/aigsim_checker.sv */
// ----------------------------------------------------------------------------
// AIG simulator port checker
// Tracks items in flight from the ports and checks result hold, occupancy and
// latency of the simulator.
// ----------------------------------------------------------------------------
module aigsim_port_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [aigsim_pkg::DATA_W-1:0] out_word,
    input logic [aigsim_pkg::NODE_W-1:0] out_node,
    input logic [aigsim_pkg::WORD_W-1:0] out_wordidx,
    input logic                          out_err
);
    import aigsim_pkg::*;

    // Queue entries plus the evaluate stage plus the output register.
    localparam int MAX_FLIGHT = QUEUE_DEPTH + 2;
    localparam int CNT_W      = $clog2(MAX_FLIGHT + 2);

    logic [CNT_W-1:0] flight_reg;
    logic [CNT_W-1:0] flight_next;
    logic             in_acc;
    logic             out_acc;

    always_comb
    begin
        in_acc      = in_valid && in_ready;
        out_acc     = out_valid && out_ready;
        flight_next = flight_reg;
        if (in_acc && !out_acc)
        begin
            flight_next = flight_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            flight_next = flight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= '0;
        end
        else
        begin
            flight_reg <= flight_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word)
            && $stable(out_node) && $stable(out_wordidx) && $stable(out_err))
        else $error("result changed while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> flight_reg != '0)
        else $error("result shown with no item in flight");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= CNT_W'(MAX_FLIGHT))
        else $error("more items in flight than the pipeline holds");

    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> flight_reg >= CNT_W'(QUEUE_DEPTH))
        else $error("input stalled while the queue has room");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && flight_reg == '0 |-> ##3 out_valid)
        else $error("result late on an empty pipeline");

endmodule

bind aig_bit_parallel_simulator aigsim_port_checker u_aigsim_port_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (items.valid),
    .in_ready    (items.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_word    (results.sim_word),
    .out_node    (results.node_out),
    .out_wordidx (results.word_out),
    .out_err     (results.order_error)
);

/* verif/aigsim_checker.sv */
// ----------------------------------------------------------------------------
// AIG simulator result checker
// Watches the item and result channels and the word-count register writes.
// It keeps its own copy of the word store, works out the word that each item
// should return and compares every result with the oldest open prediction.
// ----------------------------------------------------------------------------
module aigsim_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [aigsim_pkg::CFG_W-1:0] cfg_wdata,
    aigsim_in_if                        items,
    aigsim_out_if                       results,
    output int unsigned                 pending_count,
    output int unsigned                 error_count,
    output int unsigned                 checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import aigsim_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] sim_word;
        logic [NODE_W-1:0] node;
        logic [WORD_W-1:0] word;
        logic              order_error;
    } node_result_t;

    localparam int STORE_DEPTH = MAX_NODES_DEF * MAX_WORDS_DEF;

    logic [DATA_W-1:0] word_store [STORE_DEPTH];
    logic [CFG_W-1:0]  words_reg;
    node_result_t      expected_words [$];
    int unsigned       mismatches = 0;
    int unsigned       compared = 0;

    assign error_count   = mismatches;
    assign checked_count = compared;

    function automatic int unsigned store_slot(input logic [NODE_W-1:0] node,
                                               input logic [WORD_W-1:0] word);
        return (32'(node) % MAX_NODES_DEF) * MAX_WORDS_DEF + 32'(word);
    endfunction

    // The constant node is never stored and always reads as zero.
    function automatic logic [DATA_W-1:0] fanin_word(input logic [NODE_W-1:0] node,
                                                     input logic [WORD_W-1:0] word,
                                                     input logic              inv);
        logic [DATA_W-1:0] value;
        value = '0;
        if (32'(node) % MAX_NODES_DEF != 0)
        begin
            value = word_store[store_slot(node, word)];
        end
        return inv ? ~value : value;
    endfunction

    function automatic node_result_t predict_node_word(input logic [KIND_W-1:0] kind,
                                                       input logic [NODE_W-1:0] node,
                                                       input logic [WORD_W-1:0] word,
                                                       input logic [NODE_W-1:0] fa,
                                                       input logic              ia,
                                                       input logic [NODE_W-1:0] fb,
                                                       input logic              ib,
                                                       input logic [DATA_W-1:0] pattern);
        int unsigned  limit;
        logic         store_it;
        node_result_t res;
        limit = (words_reg == 0) ? 1 :
                (words_reg > MAX_WORDS_DEF) ? MAX_WORDS_DEF : 32'(words_reg);
        res      = '0;
        res.node = node;
        res.word = word;
        store_it = 1'b0;
        if (32'(word) < limit)
        begin
            case (kind_t'(kind))
                KIND_INPUT:
                begin
                    res.sim_word = pattern;
                    store_it     = 1'b1;
                end
                KIND_AND:
                begin
                    res.order_error = (fa >= node) || (fb >= node);
                    res.sim_word    = fanin_word(fa, word, ia) & fanin_word(fb, word, ib);
                    store_it        = 1'b1;
                end
                KIND_OUTPUT:
                begin
                    res.order_error = (fa >= node);
                    res.sim_word    = fanin_word(fa, word, ia);
                    store_it        = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (store_it && (32'(node) % MAX_NODES_DEF != 0))
            begin
                word_store[store_slot(node, word)] = res.sim_word;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 50)
        begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        node_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                word_store[i] = '0;
            end
            words_reg = CFG_W'(1);
            expected_words.delete();
            pending_count <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch($sformatf("result for node %0d word %0d with none pending",
                                              results.node_out, results.word_out));
                end
                else
                begin
                    want = expected_words.pop_front();
                    compared++;
                    if (results.sim_word !== want.sim_word)
                    begin
                        report_mismatch($sformatf("node %0d word %0d: sim_word %h, want %h",
                                                  want.node, want.word,
                                                  results.sim_word, want.sim_word));
                    end
                    if (results.node_out !== want.node)
                    begin
                        report_mismatch($sformatf("node_out %0d, want %0d",
                                                  results.node_out, want.node));
                    end
                    if (results.word_out !== want.word)
                    begin
                        report_mismatch($sformatf("node %0d: word_out %0d, want %0d",
                                                  want.node, results.word_out, want.word));
                    end
                    if (results.order_error !== want.order_error)
                    begin
                        report_mismatch($sformatf("node %0d word %0d: order_error %b, want %b",
                                                  want.node, want.word,
                                                  results.order_error, want.order_error));
                    end
                end
            end
            if (cfg_we)
            begin
                words_reg = cfg_wdata;
            end
            if (items.valid && items.ready)
            begin
                expected_words.push_back(predict_node_word(items.node_kind, items.node_index,
                                                           items.word_index, items.fanin_a,
                                                           items.invert_a, items.fanin_b,
                                                           items.invert_b, items.pattern_word));
            end
            pending_count <= expected_words.size();
        end
    end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// AIG simulator testbench
// Drives a directed set of node items covering the special cases, then
// random graphs, mostly in topological order, under several word counts
// and flow control mixes; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aigsim_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 135;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    // Word-count register value per phase, phase 0 in the low nibble.
    localparam logic [PHASES*CFG_W-1:0] WORD_SETTINGS =
        {4'd4, 4'd9, 4'd5, 4'd1, 4'd15, 4'd0, 4'd2, 4'd8};

    typedef enum int { FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH } flow_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    int unsigned pending_count;
    int unsigned error_count;
    int unsigned checked_count;
    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned words_eff = 1;
    int unsigned built_nodes [$];

    aigsim_in_if  in_ch ();
    aigsim_out_if out_ch ();

    aig_bit_parallel_simulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .items     (in_ch),
        .results   (out_ch)
    );

    aigsim_checker word_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .items         (in_ch),
        .results       (out_ch),
        .pending_count (pending_count),
        .error_count   (error_count),
        .checked_count (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offers one item after a random gap and returns at the edge that takes it.
    task automatic send_node(input logic [KIND_W-1:0] kind, input logic [NODE_W-1:0] node,
                             input logic [WORD_W-1:0] word, input logic [NODE_W-1:0] fa,
                             input logic ia, input logic [NODE_W-1:0] fb, input logic ib,
                             input logic [DATA_W-1:0] pattern);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.node_kind    <= kind;
        in_ch.node_index   <= node;
        in_ch.word_index   <= word;
        in_ch.fanin_a      <= fa;
        in_ch.invert_a     <= ia;
        in_ch.fanin_b      <= fb;
        in_ch.invert_b     <= ib;
        in_ch.pattern_word <= pattern;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // The word count may only change once every result is back.
    task automatic write_words(input logic [CFG_W-1:0] value);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        words_eff = (value == 0) ? 1 : (value > MAX_WORDS_DEF) ? MAX_WORDS_DEF : 32'(value);
    endtask

    // Fanins come only from nodes fully built in this phase, or the constant
    // node, so no entry is read before it was written. A late pick that finds a
    // candidate lands at or above the current node and so raises the order flag.
    function automatic logic [NODE_W-1:0] pick_fanin(input int unsigned cur, input bit late);
        int unsigned cand;
        if (built_nodes.size() == 0 || $urandom_range(0, 9) == 0)
        begin
            return '0;
        end
        for (int t = 0; t < 12; t++)
        begin
            cand = built_nodes[$urandom_range(0, built_nodes.size() - 1)];
            if ((cand >= cur) == late)
            begin
                return NODE_W'(cand);
            end
        end
        return '0;
    endfunction

    task automatic run_phase();
        int unsigned       start;
        int unsigned       cur;
        int unsigned       roll;
        logic [KIND_W-1:0] kind;
        logic [NODE_W-1:0] fa;
        logic [NODE_W-1:0] fb;
        logic              ia;
        logic              ib;
        start = items_sent;
        cur   = $urandom_range(1, 64);
        built_nodes.delete();
        while (items_sent - start < PHASE_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                // An item aimed at the constant node is answered but not stored.
                send_node(KIND_W'($urandom_range(0, 2)), '0,
                          WORD_W'($urandom_range(0, words_eff - 1)),
                          pick_fanin(MAX_NODES_DEF, 1'b0), 1'($urandom),
                          pick_fanin(MAX_NODES_DEF, 1'b0), 1'($urandom),
                          {$urandom, $urandom});
            end
            else if (roll < 5 && words_eff < MAX_WORDS_DEF)
            begin
                send_node(KIND_W'($urandom), NODE_W'($urandom_range(1, 1023)),
                          WORD_W'($urandom_range(words_eff, MAX_WORDS_DEF - 1)),
                          NODE_W'($urandom), 1'($urandom), NODE_W'($urandom), 1'($urandom),
                          {$urandom, $urandom});
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (built_nodes.size() == 0 || roll < 25)
                begin
                    kind = KIND_INPUT;
                end
                else if (roll < 80)
                begin
                    kind = KIND_AND;
                end
                else if (roll < 95)
                begin
                    kind = KIND_OUTPUT;
                end
                else
                begin
                    kind = KIND_SPARE;
                end
                fa = pick_fanin(cur, $urandom_range(0, 99) < 6);
                fb = pick_fanin(cur, $urandom_range(0, 99) < 6);
                ia = 1'($urandom);
                ib = 1'($urandom);
                if (kind == KIND_INPUT || kind == KIND_SPARE)
                begin
                    fa = NODE_W'($urandom);
                end
                if (kind != KIND_AND)
                begin
                    fb = NODE_W'($urandom);
                end
                for (int w = 0; w < words_eff; w++)
                begin
                    send_node(kind, NODE_W'(cur), WORD_W'(w), fa, ia, fb, ib,
                              {$urandom, $urandom});
                end
                if (kind != KIND_SPARE)
                begin
                    built_nodes.push_back(cur);
                end
                cur += $urandom_range(1, 40);
                if (cur > 1023)
                begin
                    // Start a fresh graph; nodes of the old one above it stay readable.
                    cur = $urandom_range(1, 900);
                end
            end
        end
    endtask

    initial
    begin
        in_ch.valid        <= 1'b0;
        in_ch.node_kind    <= '0;
        in_ch.node_index   <= '0;
        in_ch.word_index   <= '0;
        in_ch.fanin_a      <= '0;
        in_ch.invert_a     <= 1'b0;
        in_ch.fanin_b      <= '0;
        in_ch.invert_b     <= 1'b0;
        in_ch.pattern_word <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset word count of one.
        send_node(KIND_INPUT, 10'd1, 3'd0, 10'd0, 1'b0, 10'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_node(KIND_INPUT, 10'd2, 3'd0, 10'd1023, 1'b1, 10'd1023, 1'b1, 64'h0);
        send_node(KIND_INPUT, 10'd3, 3'd0, 10'd0, 1'b0, 10'd0, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_node(KIND_INPUT, 10'd1023, 3'd0, 10'd0, 1'b0, 10'd0, 1'b0,
                  64'h5555_5555_5555_5555);
        send_node(KIND_AND, 10'd4, 3'd0, 10'd1, 1'b0, 10'd3, 1'b0, 64'h0);
        send_node(KIND_AND, 10'd5, 3'd0, 10'd1, 1'b1, 10'd2, 1'b1, {$urandom, $urandom});
        send_node(KIND_AND, 10'd6, 3'd0, 10'd0, 1'b1, 10'd3, 1'b0, 64'h0);
        // Output nodes ignore the second fanin, even at the top index.
        send_node(KIND_OUTPUT, 10'd7, 3'd0, 10'd4, 1'b1, 10'd1023, 1'b1, 64'h0);
        send_node(KIND_OUTPUT, 10'd8, 3'd0, 10'd0, 1'b0, 10'd0, 1'b0, 64'h0);
        // Fanins at or above the node raise the order flag.
        send_node(KIND_AND, 10'd9, 3'd0, 10'd1023, 1'b0, 10'd1, 1'b0, 64'h0);
        send_node(KIND_AND, 10'd4, 3'd0, 10'd1, 1'b0, 10'd4, 1'b1, 64'h0);
        send_node(KIND_OUTPUT, 10'd10, 3'd0, 10'd1023, 1'b1, 10'd0, 1'b0, 64'h0);
        send_node(KIND_AND, 10'd3, 3'd0, 10'd3, 1'b0, 10'd1, 1'b0, 64'h0);
        // Items aimed at the constant node leave it reading zero.
        send_node(KIND_INPUT, 10'd0, 3'd0, 10'd0, 1'b0, 10'd0, 1'b0, {$urandom, $urandom});
        send_node(KIND_AND, 10'd0, 3'd0, 10'd1, 1'b0, 10'd2, 1'b1, 64'h0);
        send_node(KIND_OUTPUT, 10'd11, 3'd0, 10'd0, 1'b1, 10'd0, 1'b0, 64'h0);
        // Words past the word count and the spare kind store nothing.
        send_node(KIND_INPUT, 10'd12, 3'd1, 10'd0, 1'b0, 10'd0, 1'b0, {$urandom, $urandom});
        send_node(KIND_AND, 10'd13, 3'd7, 10'd1023, 1'b1, 10'd1023, 1'b1,
                  {$urandom, $urandom});
        send_node(KIND_SPARE, 10'd14, 3'd0, 10'd1023, 1'b1, 10'd1023, 1'b1,
                  {$urandom, $urandom});
        send_node(KIND_AND, 10'd1022, 3'd0, 10'd1023, 1'b0, 10'd4, 1'b0, 64'h0);
        send_node(KIND_OUTPUT, 10'd1023, 3'd0, 10'd1022, 1'b0, 10'd0, 1'b0, 64'h0);
        send_node(KIND_INPUT, 10'd5, 3'd0, 10'd0, 1'b0, 10'd0, 1'b0, 64'h8000_0000_0000_0001);
        send_node(KIND_AND, 10'd15, 3'd0, 10'd5, 1'b0, 10'd5, 1'b1, 64'h0);

        for (int p = 0; p < PHASES; p++)
        begin
            case (flow_t'(p % 4))
                FLOW_FREE:           begin idle_pct = 0;  stall_pct = 0;  end
                FLOW_SENDER_IDLE:    begin idle_pct = 49; stall_pct = 0;  end
                FLOW_RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 49; end
                default:             begin idle_pct = 18; stall_pct = 18; end
            endcase
            write_words(WORD_SETTINGS[p*CFG_W +: CFG_W]);
            run_phase();
        end

        in_ch.valid <= 1'b0;
        stall_pct = 0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d node items over %0d word-count settings and four flow mixes.",
                 items_sent, PHASES + 1);
        $display("Compared %0d results; %0d mismatches.", checked_count, error_count);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
